// ===== rtl/core/v3au_pkg.sv =====
`timescale 1ns / 1ps

package v3au_pkg;

  // Operation codes carried on the input tuser field.
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_CROSS = 4'd2,
    OP_DOT   = 4'd3,
    OP_SCALE = 4'd4,
    OP_DIV   = 4'd5,
    OP_LEN   = 4'd6,
    OP_DIST  = 4'd7,
    OP_NORM  = 4'd8
  } op_e;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // A clamped value together with its saturation flag.
  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } res_t;

  // Per-item control and partial results that travel down the pipeline.
  typedef struct packed {
    op_e              op;
    logic [2:0]       neg;    // sign of each component of a, flipped by a negative divisor
    logic [2:0][31:0] num;    // magnitudes of a, shifted up for normalize
    logic [31:0]      den;    // magnitude of the scalar
    logic [3:0][31:0] res;    // x, y, z, scalar
    logic             dz;
    logic             sat;
    logic             sq_ov;  // length operand out of range
  } ctl_t;

endpackage

// ===== rtl/core/vector3_arithmetic_unit.sv =====
`timescale 1ns / 1ps

// Three-component vector arithmetic unit in signed fixed point with FRAC_BITS
// fractional bits (Q16.16 by default).
// The input channel (s_axis) carries one item per handshake: the operation
// code in tuser and the vectors a, b and the scalar in tdata. The output
// channel (m_axis) returns exactly one item for every input item, in order,
// holding the result vector and the scalar result in tdata and the divide by
// zero and saturation flags in tuser.
// The datapath is a 25-stage pipeline: operand preparation, a leading zero
// count, six parallel multipliers, rounding, an 8-stage square root and an
// 8-stage divider with three lanes. Every item passes through all stages,
// and one item is accepted in every clock cycle unless the output stalls.
// The whole pipeline advances together. When the receiver holds tready low
// while an item waits at the output, every stage holds and s_axis_tready_o
// falls; nothing is lost or repeated. Bubbles move forward freely.
// Reset clears all valid bits at once; the block is ready in the first cycle
// after reset is released.
module vector3_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, 32 bits each from bit 0 up
  input  logic [223:0] s_axis_tdata_i,
  // op
  input  logic [3:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // r_x, r_y, r_z, r_scalar, 32 bits each from bit 0 up
  output logic [127:0] m_axis_tdata_o,
  // div_zero, saturated
  output logic [1:0]   m_axis_tuser_o
);
  import v3au_pkg::*;

  localparam int NST = 25;              // number of pipeline stages
  localparam int NW  = 34 + FRAC_BITS;  // width of the divider numerator
  localparam logic signed [66:0] RND_HALF = 67'sd1 <<< (FRAC_BITS - 1);

  function automatic res_t sat33(input logic signed [32:0] v);
    res_t r;
    r.sat = 1'b1;
    if (v > 33'sd2147483647) begin
      r.val = S32_MAX;
    end else if (v < -33'sd2147483648) begin
      r.val = S32_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic res_t sat67(input logic signed [66:0] v);
    res_t r;
    r.sat = 1'b1;
    if (v > 67'sd2147483647) begin
      r.val = S32_MAX;
    end else if (v < -67'sd2147483648) begin
      r.val = S32_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  logic            en;
  logic [NST:1]    vld_q;

  // Stage 1: input capture.
  op_e                op1_q;
  logic signed [31:0] a1_q [3];
  logic signed [31:0] b1_q [3];
  logic signed [31:0] s1_q;

  // Stages 2 to 4: operands.
  logic signed [31:0] a2_q [3], b2_q [3], a3_q [3], b3_q [3];
  logic signed [31:0] s2_q, s3_q;
  logic [30:0]        sqm2_d [3], sqm2_q [3], sqm3_q [3];
  logic [4:0]         k3_d, k3_q;
  logic [31:0]        mx3;
  logic [31:0]        num4_d [3];
  logic signed [32:0] xa4_d [3], ya4_d [3], xb4_d [3], yb4_d [3];
  logic signed [32:0] xa4_q [3], ya4_q [3], xb4_q [3], yb4_q [3];

  // Stages 5 to 7: products, sums and rounding.
  logic signed [65:0] pa5_q [3], pb5_q [3];
  logic signed [66:0] ls6_q [3];
  logic signed [66:0] ts6_q;
  res_t               rnd7 [3];
  res_t               rdot7;

  // Square root, stage 0 loaded at stage 6, last stage at stage 14.
  logic [63:0] sq_rad_q [0:8], sq_rad_d [1:8];
  logic [33:0] sq_rem_q [0:8], sq_rem_d [1:8];
  logic [31:0] sq_root_q [0:8], sq_root_d [1:8];
  logic [32:0] len15_d;
  logic [31:0] len15_q;

  // Divider, stage 0 loaded at stage 16, last stage at stage 24.
  logic [32:0] dv_rem_q [0:8][0:2], dv_rem_d [0:8][0:2];
  logic [31:0] dv_nl_q  [0:8][0:2], dv_nl_d  [0:8][0:2];
  logic [31:0] dv_qt_q  [0:8][0:2], dv_qt_d  [0:8][0:2];
  logic [32:0] dv_dd_q  [0:8][0:2], dv_dd_d  [0:2];
  logic        dv_ov_q  [0:8][0:2], dv_ov_d  [0:2];
  res_t        dres25 [3];

  ctl_t ctl2_d;
  ctl_t ctl_d [3:NST];
  ctl_t ctl_q [2:NST];

  // The pipeline moves as one; it only holds while a result waits.
  assign en              = !vld_q[NST] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-1:1], s_axis_tvalid_i};
    end
  end

  // Stage 2: magnitudes, differences and the add and subtract results.
  always_comb begin
    logic signed [32:0] dif;
    logic signed [32:0] sm;
    logic [32:0]        magd;
    logic [32:0]        sqm;
    logic               ov;
    res_t               rs;
    ctl2_d     = '0;
    ctl2_d.op  = op1_q;
    ctl2_d.dz  = (op1_q == OP_DIV) && (s1_q == 32'sd0);
    ctl2_d.den = s1_q[31] ? 32'(-s1_q) : 32'(s1_q);
    ov         = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // A quotient is negative when a and the scalar differ in sign.
      ctl2_d.neg[i] = a1_q[i][31] ^ ((op1_q == OP_DIV) && s1_q[31]);
      ctl2_d.num[i] = a1_q[i][31] ? 32'(-a1_q[i]) : 32'(a1_q[i]);
      dif  = 33'(b1_q[i]) - 33'(a1_q[i]);
      magd = dif[32] ? 33'(-dif) : 33'(dif);
      sqm  = (op1_q == OP_DIST) ? magd : {1'b0, ctl2_d.num[i]};
      sqm2_d[i] = sqm[30:0];
      if (sqm[32:31] != 2'b00) begin
        ov = 1'b1;
      end
      sm = (op1_q == OP_SUB) ? 33'(a1_q[i]) - 33'(b1_q[i])
                             : 33'(a1_q[i]) + 33'(b1_q[i]);
      rs = sat33(sm);
      if (op1_q == OP_ADD || op1_q == OP_SUB) begin
        ctl2_d.res[i] = rs.val;
        if (rs.sat) begin
          ctl2_d.sat = 1'b1;
        end
      end
    end
    ctl2_d.sq_ov = ov && (op1_q == OP_LEN || op1_q == OP_DIST);
  end

  // Stage 3: largest magnitude and the shift that brings it to [2^30, 2^31].
  always_comb begin
    logic [4:0] msb;
    mx3 = ctl_q[2].num[0];
    if (ctl_q[2].num[1] > mx3) begin
      mx3 = ctl_q[2].num[1];
    end
    if (ctl_q[2].num[2] > mx3) begin
      mx3 = ctl_q[2].num[2];
    end
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (mx3[i]) begin
        msb = 5'(i);
      end
    end
    k3_d = (mx3[31] || mx3[30]) ? 5'd0 : 5'(5'd30 - msb);
  end

  // Stage 4: normalize shift and multiplier operand selection.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num4_d[i] = (ctl_q[3].op == OP_NORM) ? ctl_q[3].num[i] << k3_q : ctl_q[3].num[i];
      xa4_d[i]  = '0;
      ya4_d[i]  = '0;
      xb4_d[i]  = '0;
      yb4_d[i]  = '0;
    end
    unique case (ctl_q[3].op)
      OP_CROSS: begin
        xa4_d[0] = 33'(a3_q[1]);
        ya4_d[0] = 33'(b3_q[2]);
        xb4_d[0] = 33'(a3_q[2]);
        yb4_d[0] = 33'(b3_q[1]);
        xa4_d[1] = 33'(a3_q[2]);
        ya4_d[1] = 33'(b3_q[0]);
        xb4_d[1] = 33'(a3_q[0]);
        yb4_d[1] = 33'(b3_q[2]);
        xa4_d[2] = 33'(a3_q[0]);
        ya4_d[2] = 33'(b3_q[1]);
        xb4_d[2] = 33'(a3_q[1]);
        yb4_d[2] = 33'(b3_q[0]);
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          xa4_d[i] = 33'(a3_q[i]);
          ya4_d[i] = 33'(b3_q[i]);
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          xa4_d[i] = 33'(a3_q[i]);
          ya4_d[i] = 33'(s3_q);
        end
      end
      OP_LEN, OP_DIST: begin
        for (int i = 0; i < 3; i++) begin
          xa4_d[i] = {2'b00, sqm3_q[i]};
          ya4_d[i] = {2'b00, sqm3_q[i]};
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          xa4_d[i] = {1'b0, num4_d[i]};
          ya4_d[i] = {1'b0, num4_d[i]};
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 7: rounding of the products, half a unit rounded up.
  always_comb begin
    logic signed [66:0] t;
    for (int i = 0; i < 3; i++) begin
      t       = (ls6_q[i] + RND_HALF) >>> FRAC_BITS;
      rnd7[i] = sat67(t);
    end
    t     = (ts6_q + RND_HALF) >>> FRAC_BITS;
    rdot7 = sat67(t);
  end

  // Square root stages: four result bits per stage, restoring method.
  always_comb begin
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
    logic [35:0] rem2;
    logic [35:0] trial;
    for (int j = 1; j <= 8; j++) begin
      rad  = sq_rad_q[j-1];
      rem  = sq_rem_q[j-1];
      root = sq_root_q[j-1];
      for (int s = 0; s < 4; s++) begin
        rem2  = {rem, rad[63:62]};
        trial = {2'b00, root, 2'b01};
        rad   = {rad[61:0], 2'b00};
        if (rem2 >= trial) begin
          rem  = 34'(rem2 - trial);
          root = {root[30:0], 1'b1};
        end else begin
          rem  = rem2[33:0];
          root = {root[30:0], 1'b0};
        end
      end
      sq_rad_d[j]  = rad;
      sq_rem_d[j]  = rem;
      sq_root_d[j] = root;
    end
  end

  // Stage 15: round the root to nearest.
  assign len15_d = {1'b0, sq_root_q[8]} + 33'(sq_rem_q[8] > {2'b00, sq_root_q[8]});

  // Stage 16: divider set-up. The quotient floor((2n + d) / 2d) rounds n / d
  // to nearest with ties away from zero; a quotient of 2^32 or more is
  // flagged so that it saturates.
  // Divider stages: four quotient bits per stage in each lane.
  always_comb begin
    logic [31:0]   d32;
    logic [NW-1:0] nn;
    logic [32:0]   rem;
    logic [31:0]   nl;
    logic [31:0]   qt;
    logic [33:0]   rem2;
    d32 = (ctl_q[15].op == OP_NORM) ? len15_q : ctl_q[15].den;
    for (int i = 0; i < 3; i++) begin
      nn = (NW'(ctl_q[15].num[i]) << (FRAC_BITS + 1)) + NW'(d32);
      dv_dd_d[i]     = {d32, 1'b0};
      dv_ov_d[i]     = 33'(nn[NW-1:32]) >= {d32, 1'b0};
      dv_rem_d[0][i] = dv_ov_d[i] ? 33'd0 : 33'(nn[NW-1:32]);
      dv_nl_d[0][i]  = nn[31:0];
      dv_qt_d[0][i]  = '0;
    end
    for (int j = 1; j <= 8; j++) begin
      for (int i = 0; i < 3; i++) begin
        rem = dv_rem_q[j-1][i];
        nl  = dv_nl_q[j-1][i];
        qt  = dv_qt_q[j-1][i];
        for (int s = 0; s < 4; s++) begin
          rem2 = {rem, nl[31]};
          nl   = {nl[30:0], 1'b0};
          if (rem2 >= {1'b0, dv_dd_q[j-1][i]}) begin
            rem = 33'(rem2 - {1'b0, dv_dd_q[j-1][i]});
            qt  = {qt[30:0], 1'b1};
          end else begin
            rem = rem2[32:0];
            qt  = {qt[30:0], 1'b0};
          end
        end
        dv_rem_d[j][i] = rem;
        dv_nl_d[j][i]  = nl;
        dv_qt_d[j][i]  = qt;
      end
    end
  end

  // Stage 25: sign and clamp the quotients.
  always_comb begin
    logic [31:0] q;
    for (int i = 0; i < 3; i++) begin
      q = dv_qt_q[8][i];
      dres25[i].sat = 1'b1;
      if (ctl_q[24].neg[i]) begin
        if (dv_ov_q[8][i] || q > S32_MIN) begin
          dres25[i].val = S32_MIN;
        end else begin
          dres25[i].sat = 1'b0;
          dres25[i].val = 32'(-q);
        end
      end else begin
        if (dv_ov_q[8][i] || q > S32_MAX) begin
          dres25[i].val = S32_MAX;
        end else begin
          dres25[i].sat = 1'b0;
          dres25[i].val = q;
        end
      end
    end
  end

  // Control and partial results along the pipeline.
  always_comb begin
    for (int k = 3; k <= NST; k++) begin
      ctl_d[k] = ctl_q[k-1];
    end
    if (ctl_q[2].op == OP_NORM && mx3 == 32'd0) begin
      ctl_d[3].dz = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      ctl_d[4].num[i] = num4_d[i];
    end
    if (ctl_q[6].op == OP_CROSS || ctl_q[6].op == OP_SCALE) begin
      for (int i = 0; i < 3; i++) begin
        ctl_d[7].res[i] = rnd7[i].val;
        if (rnd7[i].sat) begin
          ctl_d[7].sat = 1'b1;
        end
      end
    end
    if (ctl_q[6].op == OP_DOT) begin
      ctl_d[7].res[3] = rdot7.val;
      ctl_d[7].sat    = rdot7.sat;
    end
    if (ctl_q[14].op == OP_LEN || ctl_q[14].op == OP_DIST) begin
      if (ctl_q[14].sq_ov || len15_d > 33'(S32_MAX)) begin
        ctl_d[15].res[3] = S32_MAX;
        ctl_d[15].sat    = 1'b1;
      end else begin
        ctl_d[15].res[3] = len15_d[31:0];
      end
    end
    if ((ctl_q[24].op == OP_DIV || ctl_q[24].op == OP_NORM) && !ctl_q[24].dz) begin
      for (int i = 0; i < 3; i++) begin
        ctl_d[NST].res[i] = dres25[i].val;
        if (dres25[i].sat) begin
          ctl_d[NST].sat = 1'b1;
        end
      end
    end
  end

  // Datapath registers; the valid bits qualify them, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= op_e'(s_axis_tuser_i);
      for (int i = 0; i < 3; i++) begin
        a1_q[i]   <= s_axis_tdata_i[32*i +: 32];
        b1_q[i]   <= s_axis_tdata_i[96 + 32*i +: 32];
        a2_q[i]   <= a1_q[i];
        b2_q[i]   <= b1_q[i];
        a3_q[i]   <= a2_q[i];
        b3_q[i]   <= b2_q[i];
        sqm2_q[i] <= sqm2_d[i];
        sqm3_q[i] <= sqm2_q[i];
        xa4_q[i]  <= xa4_d[i];
        ya4_q[i]  <= ya4_d[i];
        xb4_q[i]  <= xb4_d[i];
        yb4_q[i]  <= yb4_d[i];
        pa5_q[i]  <= xa4_q[i] * ya4_q[i];
        pb5_q[i]  <= xb4_q[i] * yb4_q[i];
        ls6_q[i]  <= 67'(pa5_q[i]) - 67'(pb5_q[i]);
      end
      s1_q  <= s_axis_tdata_i[223:192];
      s2_q  <= s1_q;
      s3_q  <= s2_q;
      k3_q  <= k3_d;
      ts6_q <= 67'(pa5_q[0]) + 67'(pa5_q[1]) + 67'(pa5_q[2]);
      sq_rad_q[0]  <= 64'(67'(pa5_q[0]) + 67'(pa5_q[1]) + 67'(pa5_q[2]));
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      for (int j = 1; j <= 8; j++) begin
        sq_rad_q[j]  <= sq_rad_d[j];
        sq_rem_q[j]  <= sq_rem_d[j];
        sq_root_q[j] <= sq_root_d[j];
      end
      len15_q <= len15_d[31:0];
      for (int i = 0; i < 3; i++) begin
        dv_dd_q[0][i] <= dv_dd_d[i];
        dv_ov_q[0][i] <= dv_ov_d[i];
        for (int j = 0; j <= 8; j++) begin
          dv_rem_q[j][i] <= dv_rem_d[j][i];
          dv_nl_q[j][i]  <= dv_nl_d[j][i];
          dv_qt_q[j][i]  <= dv_qt_d[j][i];
        end
        for (int j = 1; j <= 8; j++) begin
          dv_dd_q[j][i] <= dv_dd_q[j-1][i];
          dv_ov_q[j][i] <= dv_ov_q[j-1][i];
        end
      end
      ctl_q[2] <= ctl2_d;
      for (int k = 3; k <= NST; k++) begin
        ctl_q[k] <= ctl_d[k];
      end
    end
  end

  assign m_axis_tvalid_o = vld_q[NST];
  assign m_axis_tdata_o  = {ctl_q[NST].res[3], ctl_q[NST].res[2],
                            ctl_q[NST].res[1], ctl_q[NST].res[0]};
  assign m_axis_tuser_o  = {ctl_q[NST].sat, ctl_q[NST].dz};

  // A division by zero never comes with a clamped value.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("div_zero and saturated raised together");

  // The zero flag belongs to divide and normalize only, with all results zero.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      (ctl_q[NST].op == OP_DIV || ctl_q[NST].op == OP_NORM) && m_axis_tdata_o == '0)
    else $error("div_zero with a non-zero result");

  // Scalar operations leave the result vector at zero.
  a_scalar_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (ctl_q[NST].op == OP_DOT || ctl_q[NST].op == OP_LEN ||
                        ctl_q[NST].op == OP_DIST) |-> m_axis_tdata_o[95:0] == '0)
    else $error("scalar operation returned a vector");

  // An accepted item enters the first stage.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[1])
    else $error("accepted item missing from the pipeline");

  // A stall freezes every stage.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

endmodule
